/* hw/rtl/ipmd_pkg.sv */
// Shared widths, register codes and types of the incremental PID motor drive.
package ipmd_pkg;

  // Default width of the duty outputs.
  localparam int DUTY_BITS_DEF = 16;

  // Fixed field widths.
  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int D1_W      = ERR_W + 1;
  localparam int D2_W      = ERR_W + 2;
  localparam int FRAC_BITS = 8;

  // Product, sum and rounded increment widths.
  localparam int PROD_W = GAIN_W + D2_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int INC_W  = SUM_W - FRAC_BITS;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP  = 2'd0,
    REG_INT   = 2'd1,
    REG_DERIV = 2'd2
  } cfg_reg_t;

  // Per-stage control: occupancy and the channel that the transaction drives.
  typedef struct packed {
    logic valid;
    logic backward;
  } ipmd_tag_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } ipmd_gains_t;

endpackage

/* hw/rtl/incremental_pid_motor_drive.sv */
// Incremental PID motor drive: one control tick in, one pair of duties out.
// Takes one transaction per clock cycle unless in_stall is high, and offers its
// result through four registers: an input register holding the speed error, a
// register on the three gain products, a register on the rounded increment, and
// the output register that is also the saturating drive accumulator. The
// accumulator add and clamp and the error history are the only loops. A stalled
// output holds its result while the empty stages in front of it keep taking new
// transactions. The user writes gains through the configuration port only while
// no transaction is in flight; the block itself does not enforce it.
module incremental_pid_motor_drive #(
  parameter int DUTY_BITS = ipmd_pkg::DUTY_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ipmd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ipmd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ipmd_pkg::SPEED_W-1:0]    target_speed,
  input  logic signed [ipmd_pkg::SPEED_W-1:0]    measured_speed,
  input  logic                                   direction,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [DUTY_BITS-1:0]                   duty_forward,
  output logic [DUTY_BITS-1:0]                   duty_backward,
  output logic signed [DUTY_BITS:0]              drive_level
);
  import ipmd_pkg::*;

  ipmd_gains_t              gains;
  ipmd_tag_t                in_tag;
  ipmd_tag_t                err_tag;
  ipmd_tag_t                prod_tag;
  ipmd_tag_t                inc_tag;
  ipmd_tag_t                res_tag;
  logic signed [ERR_W-1:0]  err;
  logic                     err_load;
  logic                     mult_stall;
  logic                     sum_stall;
  logic                     acc_stall;
  logic signed [PROD_W-1:0] prod_prop;
  logic signed [PROD_W-1:0] prod_int;
  logic signed [PROD_W-1:0] prod_deriv;
  logic signed [INC_W-1:0]  increment;

  // Gain registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP:  gains.prop  <= cfg_data;
        REG_INT:   gains.integ <= cfg_data;
        REG_DERIV: gains.deriv <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register holds the speed error of the accepted transaction.
  assign err_load = !err_tag.valid || !mult_stall;
  assign in_stall = !err_load;
  assign in_tag   = '{valid: in_valid, backward: direction};

  always_ff @(posedge clk) begin
    if (rst) begin
      err_tag <= '0;
    end else if (err_load) begin
      err_tag <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (err_load && in_valid) begin
      err <= ERR_W'(target_speed) - ERR_W'(measured_speed);
    end
  end

  ipmd_mult_stage u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_tag     (err_tag),
    .in_err     (err),
    .gains      (gains),
    .hold       (sum_stall),
    .stall_up   (mult_stall),
    .out_tag    (prod_tag),
    .prod_prop  (prod_prop),
    .prod_int   (prod_int),
    .prod_deriv (prod_deriv)
  );

  ipmd_sum_stage u_sum (
    .clk        (clk),
    .rst        (rst),
    .in_tag     (prod_tag),
    .prod_prop  (prod_prop),
    .prod_int   (prod_int),
    .prod_deriv (prod_deriv),
    .hold       (acc_stall),
    .stall_up   (sum_stall),
    .out_tag    (inc_tag),
    .increment  (increment)
  );

  ipmd_acc_stage #(
    .DUTY_BITS (DUTY_BITS)
  ) u_acc (
    .clk           (clk),
    .rst           (rst),
    .in_tag        (inc_tag),
    .increment     (increment),
    .hold          (out_stall),
    .stall_up      (acc_stall),
    .out_tag       (res_tag),
    .duty_forward  (duty_forward),
    .duty_backward (duty_backward),
    .drive_level   (drive_level)
  );

  assign out_valid = res_tag.valid;

endmodule

/* hw/rtl/ipmd_mult_stage.sv */
// Error history, error differences and the three gain products.
module ipmd_mult_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  ipmd_pkg::ipmd_tag_t                 in_tag,
  input  logic signed [ipmd_pkg::ERR_W-1:0]   in_err,
  input  ipmd_pkg::ipmd_gains_t               gains,
  input  logic                                hold,
  output logic                                stall_up,
  output ipmd_pkg::ipmd_tag_t                 out_tag,
  output logic signed [ipmd_pkg::PROD_W-1:0]  prod_prop,
  output logic signed [ipmd_pkg::PROD_W-1:0]  prod_int,
  output logic signed [ipmd_pkg::PROD_W-1:0]  prod_deriv
);
  import ipmd_pkg::*;

  logic                                load;
  logic signed [ERR_W-1:0]             error_prev;
  logic signed [ERR_W-1:0]             error_prev2;
  logic signed [D1_W-1:0]              diff1;
  logic signed [D2_W-1:0]              diff2;
  logic signed [GAIN_W+ERR_W-1:0]      mul_prop;
  logic signed [GAIN_W+D1_W-1:0]       mul_int;
  logic signed [GAIN_W+D2_W-1:0]       mul_deriv;

  // The stage takes a new transaction when it is empty or its content moves on.
  assign load     = !out_tag.valid || !hold;
  assign stall_up = !load;

  // First and second differences of the error.
  assign diff1 = D1_W'(in_err) - D1_W'(error_prev);
  assign diff2 = D2_W'(in_err) - (D2_W'(error_prev) <<< 1) + D2_W'(error_prev2);

  // Gain products, each registered before the sum.
  assign mul_prop  = gains.prop * in_err;
  assign mul_int   = gains.integ * diff1;
  assign mul_deriv = gains.deriv * diff2;

  // Occupancy of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (load) begin
      out_tag <= in_tag;
    end
  end

  // The older error moves down before the new one is stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_prev  <= '0;
      error_prev2 <= '0;
    end else if (load && in_tag.valid) begin
      error_prev2 <= error_prev;
      error_prev  <= in_err;
    end
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (load && in_tag.valid) begin
      prod_prop  <= PROD_W'(mul_prop);
      prod_int   <= PROD_W'(mul_int);
      prod_deriv <= PROD_W'(mul_deriv);
    end
  end

endmodule

/* hw/rtl/ipmd_sum_stage.sv */
// Sum of the gain products and rounding of the Q29.8 increment to an integer.
module ipmd_sum_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  ipmd_pkg::ipmd_tag_t                 in_tag,
  input  logic signed [ipmd_pkg::PROD_W-1:0]  prod_prop,
  input  logic signed [ipmd_pkg::PROD_W-1:0]  prod_int,
  input  logic signed [ipmd_pkg::PROD_W-1:0]  prod_deriv,
  input  logic                                hold,
  output logic                                stall_up,
  output ipmd_pkg::ipmd_tag_t                 out_tag,
  output logic signed [ipmd_pkg::INC_W-1:0]   increment
);
  import ipmd_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic                     load;
  logic signed [SUM_W-1:0]  sum;

  assign load     = !out_tag.valid || !hold;
  assign stall_up = !load;

  // Adding one half and dropping the fraction rounds ties towards plus infinity.
  assign sum = SUM_W'(prod_prop) + SUM_W'(prod_int) + SUM_W'(prod_deriv) + ROUND_HALF;

  // Occupancy of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (load) begin
      out_tag <= in_tag;
    end
  end

  // Increment register.
  always_ff @(posedge clk) begin
    if (load && in_tag.valid) begin
      increment <= sum[SUM_W-1:FRAC_BITS];
    end
  end

endmodule

/* hw/rtl/ipmd_acc_stage.sv */
// Saturating drive accumulator, output register and duty selection.
module ipmd_acc_stage #(
  parameter int DUTY_BITS = ipmd_pkg::DUTY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ipmd_pkg::ipmd_tag_t                in_tag,
  input  logic signed [ipmd_pkg::INC_W-1:0]  increment,
  input  logic                               hold,
  output logic                               stall_up,
  output ipmd_pkg::ipmd_tag_t                out_tag,
  output logic [DUTY_BITS-1:0]               duty_forward,
  output logic [DUTY_BITS-1:0]               duty_backward,
  output logic signed [DUTY_BITS:0]          drive_level
);
  import ipmd_pkg::*;

  localparam int LVL_W = DUTY_BITS + 1;
  localparam int ACC_W = ((INC_W > LVL_W) ? INC_W : LVL_W) + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = (ACC_W'(1) <<< DUTY_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

  logic                     load;
  logic signed [LVL_W-1:0]  drive_acc;
  logic signed [LVL_W-1:0]  drive_acc_next;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [LVL_W-1:0]         magnitude;

  assign load     = !out_tag.valid || !hold;
  assign stall_up = !load;

  // Add the increment and clamp to the symmetric duty range.
  assign acc_sum = ACC_W'(drive_acc) + ACC_W'(increment);

  always_comb begin
    if (acc_sum > ACC_MAX) begin
      drive_acc_next = LVL_W'(ACC_MAX);
    end else if (acc_sum < ACC_MIN) begin
      drive_acc_next = LVL_W'(ACC_MIN);
    end else begin
      drive_acc_next = LVL_W'(acc_sum);
    end
  end

  // Occupancy of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (load) begin
      out_tag <= in_tag;
    end
  end

  // The accumulator also serves as the output register of the drive level.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc <= '0;
    end else if (load && in_tag.valid) begin
      drive_acc <= drive_acc_next;
    end
  end

  // Magnitude goes to the selected channel; the other channel gets zero.
  assign magnitude     = drive_acc[LVL_W-1] ? LVL_W'(-drive_acc) : LVL_W'(drive_acc);
  assign duty_forward  = out_tag.backward ? '0 : magnitude[DUTY_BITS-1:0];
  assign duty_backward = out_tag.backward ? magnitude[DUTY_BITS-1:0] : '0;
  assign drive_level   = drive_acc;

endmodule

/* hw/rtl/ipmd_checker.sv */
// Port-level checks of the incremental PID motor drive and their binding.
module ipmd_checker #(
  parameter int DUTY_BITS = ipmd_pkg::DUTY_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [DUTY_BITS-1:0]        duty_forward,
  input logic [DUTY_BITS-1:0]        duty_backward,
  input logic signed [DUTY_BITS:0]   drive_level
);

  // No result is offered in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result stays offered with the same drive level.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_level))
    else $error("stalled result changed");

  // At most one channel carries drive.
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_forward == '0 || duty_backward == '0))
    else $error("both duties driven");

  // The drive level never reaches the negative bound outside the duty range.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_level[DUTY_BITS] && drive_level[DUTY_BITS-1:0] == '0))
    else $error("drive level out of range");

  // For a non-negative level the active duty equals the level.
  a_duty_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_level[DUTY_BITS]
      |-> (duty_forward | duty_backward) == drive_level[DUTY_BITS-1:0])
    else $error("duty does not match drive level");

endmodule

bind incremental_pid_motor_drive ipmd_checker #(.DUTY_BITS(DUTY_BITS)) u_checker (.*);
